// ===== rtl/core/deadline_timer_queue_macros.svh =====
// ----------------------------------------------------------------------------
// deadline_timer_queue assertion macros
// Shared property wrappers for the timer queue checks.
// ----------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_QUEUE_MACROS_SVH
`define DEADLINE_TIMER_QUEUE_MACROS_SVH

// same-cycle implication, disabled during reset
`define DTQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deadline_timer_queue check failed");

// next-cycle implication, disabled during reset
`define DTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deadline_timer_queue check failed");

`endif

// ===== rtl/core/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg
// Types and codes shared by the deadline timer queue and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

	// one queue slot
	typedef struct packed {
		logic        valid;
		logic [63:0] deadline;
		logic [31:0] tag;
	} entry_t;

	// command broadcast to every cell of the chain
	typedef enum logic [1:0] {
		CMD_HOLD   = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_POP    = 2'd2,
		CMD_POPINS = 2'd3
	} cell_cmd_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_SCAN    = 2'd1,
		ST_SUMMARY = 2'd2
	} state_t;

	// input op codes (s_tuser)
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_ADD  = 1'b1;

	// result kinds (m_tuser)
	localparam logic [1:0] KIND_EXPIRED = 2'd0;
	localparam logic [1:0] KIND_SUMMARY = 2'd1;
	localparam logic [1:0] KIND_ADD     = 2'd2;

	// configuration register indexes
	localparam logic REG_TASK_TAG    = 1'b0;
	localparam logic REG_TASK_PERIOD = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/dtq_cell.sv =====
// ----------------------------------------------------------------------------
// dtq_cell
// One slot of the sorted timer chain. Compares its deadline against the
// broadcast key and moves data from or to its neighbors on each command.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_cell (
	input  wire                   clk,
	input  wire                   arst_n,
	input  dtq_pkg::cell_cmd_t    cmd,
	input  dtq_pkg::entry_t       new_entry,
	input  dtq_pkg::entry_t       left_entry,
	input  wire                   left_le,
	input  dtq_pkg::entry_t       right_entry,
	input  wire                   right_le,
	output dtq_pkg::entry_t       entry,
	output logic                  le
);
	import dtq_pkg::*;

	logic        valid_q;
	logic [63:0] deadline_q;
	logic [31:0] tag_q;
	entry_t      nxt;

	assign entry = '{valid: valid_q, deadline: deadline_q, tag: tag_q};

	// slot holds a timer due no later than the key
	assign le = valid_q && (deadline_q <= new_entry.deadline);

	// next content of the slot
	always_comb begin
		nxt = entry;
		case (cmd)
			CMD_INSERT: begin
				// keep earlier timers, place new one after them, shift the rest right
				if (le) begin
					nxt = entry;
				end else if (left_le) begin
					nxt = new_entry;
				end else begin
					nxt = left_entry;
				end
			end
			CMD_POP: begin
				nxt = right_entry;
			end
			CMD_POPINS: begin
				// head leaves and the reloaded timer goes back in one step;
				// the slot where the shifted timers stop takes the new one
				if (right_le) begin
					nxt = right_entry;
				end else if (le) begin
					nxt = new_entry;
				end else begin
					nxt = entry;
				end
			end
			default: begin
				nxt = entry;
			end
		endcase
	end

	// valid bit is control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		deadline_q <= nxt.deadline;
		tag_q      <= nxt.tag;
	end

endmodule

`default_nettype wire

// ===== rtl/core/deadline_timer_queue.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_queue
// 64-bit tick counter with a sorted queue of tagged timers.
// ----------------------------------------------------------------------------
// An add item returns one add status. A tick item advances the counter,
// removes the due timers and then reports a summary: the queue is a
// chain of QUEUE_DEPTH cells kept in deadline order, and the head cell is
// removed at most once per cycle, with each reported timer passing through
// the single output register. A due task timer is removed and reloaded in
// the same cycle and produces no result. One item is processed at a time;
// the next input is taken once the tick summary is loaded for output.
`default_nettype none

module deadline_timer_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	// input items
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [63:0] s_tdata,   // [31:0] delay_ticks, [63:32] tag_value
	input  wire  [0:0]  s_tuser,   // [0] op
	// result items
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // [31:0] expired_tag, [32] task_switch,
	                               // [33] add_dropped, [39:34] zero
	output logic [1:0]  m_tuser,   // [1:0] result_kind
	output logic        m_tlast,   // last_of_run
	// configuration
	input  wire         cfg_we,
	input  wire  [0:0]  cfg_index,
	input  wire  [31:0] cfg_data
);
	import dtq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// registers
	logic signed [31:0] task_tag_q;
	logic [31:0]        task_period_q;
	logic [63:0]        tick_count_q;
	logic [CW-1:0]      pop_cnt_q;
	logic               sw_q;
	state_t             state_q, state_nxt;

	logic               m_tvalid_q;
	logic [1:0]         kind_q;
	logic signed [31:0] exp_tag_q;
	logic               task_sw_q;
	logic               dropped_q;
	logic               last_q;

	// input fields
	logic               in_op;
	logic [31:0]        in_delay;
	logic signed [31:0] in_tag;

	assign in_op    = s_tuser[0];
	assign in_delay = s_tdata[31:0];
	assign in_tag   = s_tdata[63:32];

	// chain signals
	entry_t                 cell_ent [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] cell_le;
	logic [QUEUE_DEPTH-1:0] cell_valid;
	cell_cmd_t              cmd;
	entry_t                 new_entry;

	// control from the sequencer
	logic        out_free;
	logic        full;
	logic        head_due;
	logic        pop_ok;
	logic        acc_tick;
	logic        acc_add;
	logic        ld_out;
	logic [1:0]  ld_kind;
	logic [31:0] ld_tag;
	logic        ld_sw;
	logic        ld_drop;
	logic        ld_last;
	logic        pop_inc;
	logic        sw_set;

	// saturating deadline: tick plus delay (add) or plus period (reload)
	logic [31:0] per_eff;
	logic [31:0] add_opnd;
	logic [64:0] dl_sum;

	assign per_eff  = (task_period_q == '0) ? 32'd1 : task_period_q;
	assign add_opnd = (state_q == ST_IDLE) ? in_delay : per_eff;
	assign dl_sum   = {1'b0, tick_count_q} + {33'd0, add_opnd};

	assign new_entry.valid    = 1'b1;
	assign new_entry.deadline = dl_sum[64] ? {64{1'b1}} : dl_sum[63:0];
	assign new_entry.tag      = (state_q == ST_IDLE) ? in_tag : task_tag_q;

	// cell chain
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t l_ent, r_ent;
		logic   l_le, r_le;

		if (i == 0) begin : g_first
			assign l_ent = '0;
			assign l_le  = 1'b1;
		end else begin : g_mid_l
			assign l_ent = cell_ent[i-1];
			assign l_le  = cell_le[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign r_ent = '0;
			assign r_le  = 1'b0;
		end else begin : g_mid_r
			assign r_ent = cell_ent[i+1];
			assign r_le  = cell_le[i+1];
		end

		dtq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.new_entry   (new_entry),
			.left_entry  (l_ent),
			.left_le     (l_le),
			.right_entry (r_ent),
			.right_le    (r_le),
			.entry       (cell_ent[i]),
			.le          (cell_le[i])
		);

		assign cell_valid[i] = cell_ent[i].valid;
	end

	// status of the queue
	assign full     = cell_valid[QUEUE_DEPTH-1];
	assign head_due = cell_ent[0].valid && (cell_ent[0].deadline <= tick_count_q);
	assign pop_ok   = pop_cnt_q < CW'(QUEUE_DEPTH);
	assign out_free = !m_tvalid_q || m_tready;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && out_free && (in_op == OP_TICK)) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!(pop_ok && head_due)) begin
					state_nxt = ST_SUMMARY;
				end
			end
			ST_SUMMARY: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		acc_tick = 1'b0;
		acc_add  = 1'b0;
		cmd      = CMD_HOLD;
		ld_out   = 1'b0;
		ld_kind  = KIND_EXPIRED;
		ld_tag   = '0;
		ld_sw    = 1'b0;
		ld_drop  = 1'b0;
		ld_last  = 1'b0;
		pop_inc  = 1'b0;
		sw_set   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = out_free;
				if (s_tvalid && out_free) begin
					if (in_op == OP_ADD) begin
						acc_add = 1'b1;
						ld_out  = 1'b1;
						ld_kind = KIND_ADD;
						ld_drop = full;
						ld_last = 1'b1;
						if (!full) begin
							cmd = CMD_INSERT;
						end
					end else begin
						acc_tick = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (pop_ok && head_due) begin
					if (cell_ent[0].tag == task_tag_q) begin
						// task timer: reload, no result
						cmd     = CMD_POPINS;
						pop_inc = 1'b1;
						sw_set  = 1'b1;
					end else if (out_free) begin
						cmd     = CMD_POP;
						pop_inc = 1'b1;
						ld_out  = 1'b1;
						ld_kind = KIND_EXPIRED;
						ld_tag  = cell_ent[0].tag;
					end
				end
			end
			ST_SUMMARY: begin
				if (out_free) begin
					ld_out  = 1'b1;
					ld_kind = KIND_SUMMARY;
					ld_sw   = sw_q;
					ld_last = 1'b1;
				end
			end
			default: begin
				cmd = CMD_HOLD;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			tick_count_q  <= '0;
			pop_cnt_q     <= '0;
			sw_q          <= 1'b0;
			task_tag_q    <= '0;
			task_period_q <= 32'd2;
			m_tvalid_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (acc_tick) begin
				tick_count_q <= tick_count_q + 64'd1;
				pop_cnt_q    <= '0;
				sw_q         <= 1'b0;
			end else begin
				if (pop_inc) begin
					pop_cnt_q <= pop_cnt_q + CW'(1);
				end
				if (sw_set) begin
					sw_q <= 1'b1;
				end
			end
			if (cfg_we) begin
				case (cfg_index[0])
					REG_TASK_TAG:    task_tag_q    <= cfg_data;
					REG_TASK_PERIOD: task_period_q <= cfg_data;
					default:         task_tag_q    <= task_tag_q;
				endcase
			end
			if (ld_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (ld_out) begin
			kind_q    <= ld_kind;
			exp_tag_q <= ld_tag;
			task_sw_q <= ld_sw;
			dropped_q <= ld_drop;
			last_q    <= ld_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, dropped_q, task_sw_q, exp_tag_q};
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	// checks
`include "deadline_timer_queue_macros.svh"

	// valid slots form a prefix of the chain
	`DTQ_ASSERT_NOW(a_valid_prefix, clk, arst_n, 1'b1, ((cell_valid >> 1) & ~cell_valid) == '0)
	// chain head is never later than its successor
	`DTQ_ASSERT_NOW(a_head_sorted, clk, arst_n, cell_valid[1], cell_ent[0].deadline <= cell_ent[1].deadline)
	// an add on a non-full queue adds exactly one slot
	`DTQ_ASSERT_NEXT(a_add_grows, clk, arst_n, acc_add && !full, $countones(cell_valid) == $past($countones(cell_valid)) + 1)
	// removals per tick stay within the queue depth
	`DTQ_ASSERT_NOW(a_pop_bound, clk, arst_n, 1'b1, pop_cnt_q <= CW'(QUEUE_DEPTH))

endmodule

`default_nettype wire

// ===== tb/tb_deadline_timer_queue.sv =====
// ----------------------------------------------------------------------------
// tb_deadline_timer_queue
// Self-checking bench for the tick counter and sorted timer queue.
// ----------------------------------------------------------------------------
// A short directed table covers the empty-queue tick, field extremes, equal
// deadlines, a full queue with a dropped add, and a tick that retires a full
// queue at once. Random phases follow, each with its own task tag and
// reload period. A behavioral copy of the queue predicts every result item,
// and the monitor compares each one field by field in order of arrival.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_deadline_timer_queue;
	import dtq_pkg::*;

	localparam int DEPTH       = 16;
	localparam int DRAIN_PAD   = DEPTH + 8;
	localparam int LONG_STALL  = 300;
	localparam int DRAIN_GUARD = 20000;

	// one result item, as the block reports it
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] tag;
		logic        sw;
		logic        drop;
		logic        last;
	} timer_result_t;

	// one directed row; reps repeats the row with the tag counting up
	typedef struct packed {
		logic          op;
		logic [31:0]   delay;
		logic [31:0]   tag;
		logic [4:0]    reps;
		logic          pinned;
		timer_result_t pin;
	} stim_row_t;

	localparam timer_result_t RES_NONE      = '0;
	localparam timer_result_t RES_IDLE_TICK =
		'{kind: KIND_SUMMARY, tag: 32'd0, sw: 1'b0, drop: 1'b0, last: 1'b1};
	localparam timer_result_t RES_ADD_OK    =
		'{kind: KIND_ADD, tag: 32'd0, sw: 1'b0, drop: 1'b0, last: 1'b1};
	localparam timer_result_t RES_ADD_DROP  =
		'{kind: KIND_ADD, tag: 32'd0, sw: 1'b0, drop: 1'b1, last: 1'b1};

	// directed table, 25 items in all
	stim_row_t dir_rows [10] = '{
		'{OP_TICK, 32'd0,          32'd0,          5'd1,  1'b1, RES_IDLE_TICK},
		'{OP_ADD,  32'd0,          32'h7FFF_FFFF,  5'd1,  1'b1, RES_ADD_OK},
		'{OP_ADD,  32'd1,          32'd0,          5'd1,  1'b1, RES_ADD_OK},
		'{OP_ADD,  32'd1,          32'h1234_5678,  5'd1,  1'b1, RES_ADD_OK},
		'{OP_TICK, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  5'd1,  1'b0, RES_NONE},
		'{OP_ADD,  32'd2,          32'h0000_0100,  5'd15, 1'b0, RES_NONE},
		'{OP_ADD,  32'hFFFF_FFFF,  32'h8000_0000,  5'd1,  1'b1, RES_ADD_DROP},
		'{OP_TICK, 32'd0,          32'd0,          5'd2,  1'b0, RES_NONE},
		'{OP_ADD,  32'hFFFF_FFFF,  32'h8000_0000,  5'd1,  1'b1, RES_ADD_OK},
		'{OP_TICK, 32'd0,          32'd0,          5'd1,  1'b0, RES_NONE}
	};

	// DUT ports
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata   = '0;
	logic [0:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_we    = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [31:0] cfg_data  = '0;

	// directed expectation travels alongside the item it belongs to
	logic          pin_active = 1'b0;
	timer_result_t pin_result = '0;

	// predicted queue state
	logic [63:0]   ticks = '0;
	logic [63:0]   timer_deadline [DEPTH];
	logic [31:0]   timer_tag [DEPTH];
	int            timer_count = 0;
	logic [31:0]   cur_task_tag = 32'd0;
	logic [31:0]   cur_task_period = 32'd2;
	timer_result_t results_due [$];
	int            due_before;

	// pacing and bookkeeping
	int tx_idle_pct = 12;
	int rx_idle_pct = 61;
	bit stall_req   = 1'b0;
	bit stall_done  = 1'b0;
	int fail_count  = 0;
	int n_results   = 0;
	int n_ticks     = 0;
	int n_adds      = 0;
	int n_expired   = 0;
	int n_switches  = 0;
	int n_dropped   = 0;
	int n_settings  = 0;

	deadline_timer_queue #(
		.QUEUE_DEPTH(DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// queue predictor
	// ------------------------------------------------------------------

	// deadline sum clamps at the top of the 64-bit range
	function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [31:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {33'd0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	// sorted insert behind every timer due no later
	task automatic insert_timer(input logic [63:0] dl, input logic [31:0] tg, output bit ok);
		int pos;
		int i;
		ok = 1'b0;
		if (timer_count >= DEPTH)
			return;
		pos = 0;
		while (pos < timer_count && timer_deadline[pos] <= dl)
			pos++;
		for (i = timer_count; i > pos; i--) begin
			timer_deadline[i] = timer_deadline[i - 1];
			timer_tag[i]      = timer_tag[i - 1];
		end
		timer_deadline[pos] = dl;
		timer_tag[pos]      = tg;
		timer_count++;
		ok = 1'b1;
	endtask

	task automatic pop_head;
		int i;
		for (i = 0; i + 1 < timer_count; i++) begin
			timer_deadline[i] = timer_deadline[i + 1];
			timer_tag[i]      = timer_tag[i + 1];
		end
		timer_count--;
	endtask

	// runs one accepted item and queues the results it should cause
	task automatic apply_timer_item(input logic op, input logic [31:0] delay,
	                                input logic [31:0] tag);
		timer_result_t r;
		logic [31:0]   head_tag;
		logic [31:0]   per;
		bit            ok;
		bit            sw;
		int            pops;
		r = '0;
		if (op == OP_ADD) begin
			insert_timer(sat_sum(ticks, delay), tag, ok);
			r.kind = KIND_ADD;
			r.drop = !ok;
			r.last = 1'b1;
			results_due.push_back(r);
			return;
		end
		ticks = ticks + 64'd1;
		sw = 1'b0;
		for (pops = 0; pops < DEPTH; pops++) begin
			if (timer_count == 0 || timer_deadline[0] > ticks)
				break;
			head_tag = timer_tag[0];
			pop_head();
			if (head_tag == cur_task_tag) begin
				// context switch timer: reload instead of reporting
				per = (cur_task_period == 32'd0) ? 32'd1 : cur_task_period;
				sw = 1'b1;
				insert_timer(sat_sum(ticks, per), cur_task_tag, ok);
			end else begin
				r = '0;
				r.kind = KIND_EXPIRED;
				r.tag  = head_tag;
				results_due.push_back(r);
			end
		end
		r = '0;
		r.kind = KIND_SUMMARY;
		r.sw   = sw;
		r.last = 1'b1;
		results_due.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string field, input logic [63:0] want,
	                               input logic [63:0] got);
		$display("[%0t] mismatch on result %0d, %s: expected %0h, got %0h",
			$time, n_results, field, want, got);
		fail_count++;
	endtask

	task automatic check_result;
		timer_result_t want;
		if (results_due.size() == 0) begin
			report_mismatch("unexpected result, kind", 64'd0, {62'd0, m_tuser});
			return;
		end
		want = results_due.pop_front();
		if (m_tuser !== want.kind)
			report_mismatch("result_kind", 64'(want.kind), 64'(m_tuser));
		if (m_tdata[31:0] !== want.tag)
			report_mismatch("expired_tag", 64'(want.tag), 64'(m_tdata[31:0]));
		if (m_tdata[32] !== want.sw)
			report_mismatch("task_switch", 64'(want.sw), 64'(m_tdata[32]));
		if (m_tdata[33] !== want.drop)
			report_mismatch("add_dropped", 64'(want.drop), 64'(m_tdata[33]));
		if (m_tdata[39:34] !== 6'd0)
			report_mismatch("tdata padding", 64'd0, 64'(m_tdata[39:34]));
		if (m_tlast !== want.last)
			report_mismatch("last_of_run", 64'(want.last), 64'(m_tlast));
		if (want.kind == KIND_EXPIRED)
			n_expired++;
		if (want.sw)
			n_switches++;
		if (want.drop)
			n_dropped++;
	endtask

	// register writes, accepted items and accepted results, all at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == REG_TASK_TAG)
					cur_task_tag = cfg_data;
				else
					cur_task_period = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				due_before = results_due.size();
				apply_timer_item(s_tuser[0], s_tdata[31:0], s_tdata[63:32]);
				if (pin_active) begin
					while (results_due.size() > due_before)
						void'(results_due.pop_back());
					results_due.push_back(pin_result);
				end
			end
			if (m_tvalid && m_tready) begin
				check_result();
				n_results++;
			end
		end
	end

	// ------------------------------------------------------------------
	// result side: random stalls, plus one long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		forever begin
			@(posedge clk);
			if (stall_req && !stall_done) begin
				m_tready <= 1'b0;
				repeat (LONG_STALL - 1) @(posedge clk);
				stall_done = 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// item side
	// ------------------------------------------------------------------

	// offer one item and hold it until accepted; returns at the accepting edge
	task automatic send_item(input logic op, input logic [31:0] delay, input logic [31:0] tag,
	                         input logic pinned, input timer_result_t pin);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid   <= 1'b1;
		s_tuser    <= op;
		s_tdata    <= {tag, delay};
		pin_active <= pinned;
		pin_result <= pin;
		do
			@(posedge clk);
		while (!s_tready);
		if (op == OP_TICK)
			n_ticks++;
		else
			n_adds++;
	endtask

	// let every predicted result come back, then let the block settle
	task automatic wait_drained;
		int guard;
		s_tvalid <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (results_due.size() != 0 && guard < DRAIN_GUARD) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	// both registers, write enable held across both writes
	task automatic write_config(input logic [31:0] tag, input logic [31:0] period);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TASK_TAG;
		cfg_data  <= tag;
		@(posedge clk);
		cfg_index <= REG_TASK_PERIOD;
		cfg_data  <= period;
		@(posedge clk);
		cfg_we    <= 1'b0;
		n_settings++;
	endtask

	// mostly short delays so timers expire; a few far ones stay for good
	function automatic logic [31:0] pick_delay();
		int pick;
		pick = $urandom_range(99);
		if (pick < 65)
			return $urandom_range(6);
		if (pick < 97)
			return $urandom_range(40, 7);
		return $urandom_range(1) ? 32'hFFFF_FFFF : $urandom;
	endfunction

	function automatic logic [31:0] pick_tag();
		if ($urandom_range(99) < 10)
			return cur_task_tag;
		return $urandom;
	endfunction

	task automatic run_phase(input int n_items, input int tx_pct, input int rx_pct,
	                         input bit long_hold);
		int          sent;
		int          burst;
		logic [31:0] dly;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		if (long_hold)
			stall_req = 1'b1;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 4) begin
				// group of timers due together, then ticks to retire them
				burst = $urandom_range(16, 4);
				dly   = $urandom_range(2);
				repeat (burst)
					send_item(OP_ADD, dly, pick_tag(), 1'b0, RES_NONE);
				repeat (3)
					send_item(OP_TICK, $urandom, $urandom, 1'b0, RES_NONE);
				sent += burst + 3;
			end else begin
				if ($urandom_range(99) < 45)
					send_item(OP_TICK, $urandom, $urandom, 1'b0, RES_NONE);
				else
					send_item(OP_ADD, pick_delay(), pick_tag(), 1'b0, RES_NONE);
				sent++;
			end
		end
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under the reset register values
		foreach (dir_rows[r]) begin
			for (int k = 0; k < dir_rows[r].reps; k++)
				send_item(dir_rows[r].op, dir_rows[r].delay, dir_rows[r].tag + k,
					dir_rows[r].pinned, dir_rows[r].pin);
		end
		wait_drained();

		// random phases, one register setting each
		write_config($urandom, 32'd1);
		run_phase(48, 12, 61, 1'b0);
		write_config(32'h8000_0000, 32'd0);
		run_phase(48, 61, 12, 1'b0);
		write_config(32'h7FFF_FFFF, $urandom_range(9, 2));
		run_phase(48, 0, 0, 1'b1);
		write_config($urandom, 32'hFFFF_FFFF);
		run_phase(48, 0, 0, 1'b0);

		// anything still predicted never showed up
		while (results_due.size() != 0) begin
			report_mismatch("result never arrived, kind", 64'(results_due[0].kind), 64'd0);
			void'(results_due.pop_front());
		end

		$display("Run covered %0d items (%0d ticks, %0d adds) under %0d register settings.",
			n_ticks + n_adds, n_ticks, n_adds, n_settings + 1);
		$display("Checked %0d results: %0d expirations, %0d task switches, %0d dropped adds.",
			n_results, n_expired, n_switches, n_dropped);
		if (fail_count == 0)
			$display("deadline_timer_queue verification clean");
		else
			$display("deadline_timer_queue verification failed");
		$finish;
	end

	// hard stop if the run hangs
	initial begin
		#2_000_000;
		$display("deadline_timer_queue verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== deadline_timer_queue.f =====
+incdir+rtl/core
rtl/core/dtq_pkg.sv
rtl/core/dtq_cell.sv
rtl/core/deadline_timer_queue.sv
tb/tb_deadline_timer_queue.sv
